// ----- src/assert_macros.svh -----
// Assertion macros shared by the watchdog supervision manager modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- src/wsm_pkg.sv -----
// Package with shared types, constants and codes of the watchdog supervision manager.
package wsm_pkg;
    localparam int ENTITIES_DEF = 4;
    localparam int TRANSITIONS_DEF = 8;
    localparam int DEADLINES_DEF = 8;
    localparam int ALIVE_REGS = 4;
    localparam logic [7:0] CP_INITIAL = 8'hFF;

    localparam logic [2:0] MODE_CHECKPOINT = 3'd0;
    localparam logic [2:0] MODE_CYCLE = 3'd1;
    localparam logic [2:0] MODE_RESUME = 3'd2;
    localparam logic [2:0] MODE_CLEAR = 3'd3;
    localparam logic [2:0] MODE_WR_TRANS = 3'd4;
    localparam logic [2:0] MODE_WR_DEAD = 3'd5;

    localparam logic [2:0] CFG_ENTITY_COUNT = 3'd0;
    localparam logic [2:0] CFG_ALIVE_MIN0 = 3'd1;
    localparam logic [2:0] CFG_ALIVE_MIN3 = 3'd4;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_FAILED = 2'd1;
    localparam logic [1:0] STATUS_DEACT = 2'd2;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  entity;
        logic [7:0]  checkpoint;
        logic [31:0] now_ms;
        logic [2:0]  rule_index;
        logic        rule_valid;
        logic [7:0]  rule_from;
        logic [31:0] limit_min_ms;
        logic [31:0] limit_max_ms;
    } in_item_t;

    typedef struct packed {
        logic       accepted;
        logic [1:0] entity_status;
        logic       watchdog_refresh;
        logic       logical_violation;
        logic       deadline_violation;
    } out_item_t;

    // Classified command passed from the front part to the back part.
    typedef struct packed {
        in_item_t item;
        logic     ent_ok;
        logic     slot_ok;
    } cmd_t;
endpackage

// ----- src/wsm_if.sv -----
// Valid/ready channel interfaces for items, results and configuration writes.
interface wsm_in_if;
    logic valid;
    logic ready;
    logic [2:0]  mode;
    logic [7:0]  entity;
    logic [7:0]  checkpoint;
    logic [31:0] now_ms;
    logic [2:0]  rule_index;
    logic        rule_valid;
    logic [7:0]  rule_from;
    logic [31:0] limit_min_ms;
    logic [31:0] limit_max_ms;
    modport source (output valid, mode, entity, checkpoint, now_ms, rule_index, rule_valid,
                    rule_from, limit_min_ms, limit_max_ms, input ready);
    modport sink (input valid, mode, entity, checkpoint, now_ms, rule_index, rule_valid,
                  rule_from, limit_min_ms, limit_max_ms, output ready);
endinterface

interface wsm_out_if;
    logic valid;
    logic ready;
    logic       accepted;
    logic [1:0] entity_status;
    logic       watchdog_refresh;
    logic       logical_violation;
    logic       deadline_violation;
    modport source (output valid, accepted, entity_status, watchdog_refresh,
                    logical_violation, deadline_violation, input ready);
    modport sink (input valid, accepted, entity_status, watchdog_refresh,
                  logical_violation, deadline_violation, output ready);
endinterface

interface wsm_cfg_if;
    logic valid;
    logic ready;
    logic [2:0] index;
    logic [7:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- src/wsm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module wsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- src/wsm_front.sv -----
// Front part: accepts input beats, classifies them and holds a two-entry command queue.
module wsm_front #(
    parameter int ENTITIES = wsm_pkg::ENTITIES_DEF,
    parameter int TRANSITIONS = wsm_pkg::TRANSITIONS_DEF,
    parameter int DEADLINES = wsm_pkg::DEADLINES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    wsm_in_if.sink          in_ch,
    input  logic [2:0]      entity_count,
    output wsm_pkg::cmd_t   cmd,
    output logic            cmd_valid,
    input  logic            cmd_take
);
    import wsm_pkg::*;
    `include "assert_macros.svh"

    localparam int QD = 2;

    cmd_t       q_reg [QD];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [4:0] in_use;
    logic       push;
    cmd_t       c_new;
    logic       wide_mode;
    logic [5:0] slot_lim;

    assign in_use = ({2'b0, entity_count} > 5'(ENTITIES)) ? 5'(ENTITIES) : {2'b0, entity_count};
    assign in_ch.ready = (cnt_reg != 2'(QD));
    assign push = in_ch.valid && in_ch.ready;

    always_comb
    begin
        c_new.item.mode = in_ch.mode;
        c_new.item.entity = in_ch.entity;
        c_new.item.checkpoint = in_ch.checkpoint;
        c_new.item.now_ms = in_ch.now_ms;
        c_new.item.rule_index = in_ch.rule_index;
        c_new.item.rule_valid = in_ch.rule_valid;
        c_new.item.rule_from = in_ch.rule_from;
        c_new.item.limit_min_ms = in_ch.limit_min_ms;
        c_new.item.limit_max_ms = in_ch.limit_max_ms;
        c_new.ent_ok = {1'b0, in_ch.entity} < {4'b0, in_use};
        wide_mode = (in_ch.mode == MODE_WR_TRANS);
        slot_lim = wide_mode ? 6'(TRANSITIONS) : 6'(DEADLINES);
        c_new.slot_ok = {3'b0, in_ch.rule_index} < slot_lim;
    end

    assign cmd = q_reg[rp_reg];
    assign cmd_valid = (cnt_reg != 2'd0);

    always_comb
    begin
        wp_next = push ? ~wp_reg : wp_reg;
        rp_next = cmd_take ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(cmd_take);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= c_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    `ASSERT_IMPL(a_no_take_empty, clk, rst_n, cmd_take, cnt_reg != 2'd0)
    `ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= 2'(QD))
    `ASSERT_NEXT(a_push_counts, clk, rst_n, push && !cmd_take, cnt_reg == $past(cnt_reg) + 2'd1)
endmodule

// ----- src/wsm_back.sv -----
// Back part: executes commands against entity state and rule tables, sequencing rule scans.
module wsm_back #(
    parameter int ENTITIES = wsm_pkg::ENTITIES_DEF,
    parameter int TRANSITIONS = wsm_pkg::TRANSITIONS_DEF,
    parameter int DEADLINES = wsm_pkg::DEADLINES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  wsm_pkg::cmd_t        cmd,
    input  logic                 cmd_valid,
    output logic                 cmd_take,
    input  logic [2:0]           entity_count,
    input  logic [7:0]           alive_min [wsm_pkg::ALIVE_REGS],
    wsm_out_if.source            out_ch
);
    import wsm_pkg::*;
    `include "assert_macros.svh"

    localparam int EW = (ENTITIES > 1) ? $clog2(ENTITIES) : 1;
    localparam int TW = (TRANSITIONS > 1) ? $clog2(TRANSITIONS) : 1;
    localparam int DW = (DEADLINES > 1) ? $clog2(DEADLINES) : 1;
    localparam int TD = ENTITIES * TRANSITIONS;
    localparam int DD = ENTITIES * DEADLINES;
    localparam int TAW = (TD > 1) ? $clog2(TD) : 1;
    localparam int DAW = (DD > 1) ? $clog2(DD) : 1;
    localparam int SW = ((TW > DW) ? TW : DW) + 1;
    localparam int NW = EW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_CYCLE = 3'd2;
    localparam logic [2:0] S_DCHK = 3'd3;
    localparam logic [2:0] S_OUT = 3'd4;

    logic [2:0]      st_reg, st_next;
    logic [SW-1:0]   idx_reg, idx_next;
    cmd_t            c_reg;
    logic            tfound_reg, dfound_reg, ddone_reg;
    logic [DW-1:0]   dslot_reg;
    logic [31:0]     el_reg;
    logic            refresh_reg;
    out_item_t       res_reg;
    logic            ovalid_reg;

    logic [7:0]      acnt_reg [ENTITIES];
    logic [ENTITIES-1:0] af_reg, lf_reg, df_reg;
    logic [7:0]      lcp_reg [ENTITIES];
    logic [31:0]     lt_reg [ENTITIES];
    logic [TRANSITIONS-1:0] tv_reg [ENTITIES];
    logic [DEADLINES-1:0]   dv_reg [ENTITIES];

    logic [EW-1:0]   ent;
    logic [4:0]      in_use;
    logic [15:0]     t_rd, d_rd;
    logic [63:0]     l_rd;
    logic            t_we, d_we;
    logic [TAW-1:0]  t_wa, t_ra;
    logic [DAW-1:0]  d_wa, d_ra;
    logic [TW-1:0]   tslot_rd;
    logic [DW-1:0]   dslot_rd;
    logic            t_hit, d_hit;
    logic            lviol, dviol;
    logic [1:0]      status;
    logic            alive_ok;
    logic [7:0]      amin;
    logic [EW-1:0]   ce;

    assign ent = c_reg.item.entity[EW-1:0];
    assign in_use = ({2'b0, entity_count} > 5'(ENTITIES)) ? 5'(ENTITIES) : {2'b0, entity_count};
    assign cmd_take = cmd_valid && (st_reg == S_IDLE) && !ovalid_reg;

    // Table write comes straight from the queue head; scan reads use idx_reg.
    assign t_we = cmd_take && cmd.ent_ok && cmd.slot_ok && (cmd.item.mode == MODE_WR_TRANS);
    assign d_we = cmd_take && cmd.ent_ok && cmd.slot_ok && (cmd.item.mode == MODE_WR_DEAD);
    assign t_wa = TAW'({cmd.item.entity[EW-1:0], cmd.item.rule_index[TW-1:0]});
    assign d_wa = DAW'({cmd.item.entity[EW-1:0], cmd.item.rule_index[DW-1:0]});
    assign tslot_rd = idx_reg[TW-1:0];
    assign dslot_rd = (st_reg == S_DCHK) ? dslot_reg : idx_reg[DW-1:0];
    assign t_ra = TAW'({ent, tslot_rd});
    assign d_ra = DAW'({ent, dslot_rd});

    wsm_ram #(.WIDTH(16), .DEPTH(TD)) u_trans (
        .clk(clk), .we(t_we), .waddr(t_wa),
        .wdata({cmd.item.rule_from, cmd.item.checkpoint}), .raddr(t_ra), .rdata(t_rd));
    wsm_ram #(.WIDTH(16), .DEPTH(DD)) u_dpair (
        .clk(clk), .we(d_we), .waddr(d_wa),
        .wdata({cmd.item.rule_from, cmd.item.checkpoint}), .raddr(d_ra), .rdata(d_rd));
    wsm_ram #(.WIDTH(64), .DEPTH(DD)) u_dlim (
        .clk(clk), .we(d_we), .waddr(d_wa),
        .wdata({cmd.item.limit_min_ms, cmd.item.limit_max_ms}), .raddr(d_ra), .rdata(l_rd));

    // Scan index idx_reg-1 is the slot whose data is on the RAM outputs now.
    logic [SW-1:0] prev;
    assign prev = idx_reg - SW'(1);
    assign t_hit = (prev < SW'(TRANSITIONS)) && (idx_reg != '0)
                   && tv_reg[ent][prev[TW-1:0]]
                   && t_rd[15:8] == lcp_reg[ent] && t_rd[7:0] == c_reg.item.checkpoint;
    assign d_hit = (prev < SW'(DEADLINES)) && (idx_reg != '0)
                   && dv_reg[ent][prev[DW-1:0]]
                   && d_rd[15:8] == lcp_reg[ent] && d_rd[7:0] == c_reg.item.checkpoint;

    localparam int SMAX = (TRANSITIONS > DEADLINES) ? TRANSITIONS : DEADLINES;

    always_comb
    begin
        ce = idx_reg[EW-1:0];
        amin = (32'(idx_reg) < ALIVE_REGS) ? alive_min[idx_reg[1:0]] : 8'd1;
        alive_ok = !(acnt_reg[ce] < amin);
        lviol = !tfound_reg;
        dviol = ddone_reg && ((el_reg < l_rd[63:32]) || (el_reg > l_rd[31:0]));
        status = STATUS_OK;
        if (!({1'b0, c_reg.item.entity} < {4'b0, in_use}))
        begin
            status = STATUS_DEACT;
        end
        else if (af_reg[ent] || lf_reg[ent] || df_reg[ent])
        begin
            status = STATUS_FAILED;
        end
    end

    always_comb
    begin
        st_next = st_reg;
        idx_next = idx_reg;
        unique case (st_reg)
            S_IDLE:
            begin
                idx_next = '0;
                if (cmd_take)
                begin
                    priority if (cmd.item.mode == MODE_CHECKPOINT && cmd.ent_ok)
                    begin
                        st_next = S_SCAN;
                    end
                    else if (cmd.item.mode == MODE_CYCLE)
                    begin
                        st_next = S_CYCLE;
                    end
                    else
                    begin
                        st_next = S_OUT;
                    end
                end
            end
            S_SCAN:
            begin
                idx_next = idx_reg + SW'(1);
                if (idx_reg == SW'(SMAX))
                begin
                    st_next = S_DCHK;
                end
            end
            S_CYCLE:
            begin
                idx_next = idx_reg + SW'(1);
                if ({{(6-SW){1'b0}}, idx_reg} + 6'd1 >= {1'b0, in_use})
                begin
                    st_next = S_OUT;
                end
            end
            S_DCHK:
            begin
                st_next = S_OUT;
            end
            S_OUT:
            begin
                st_next = S_IDLE;
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            c_reg <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            idx_reg <= '0;
            tfound_reg <= 1'b0;
            dfound_reg <= 1'b0;
            ddone_reg <= 1'b0;
            dslot_reg <= '0;
            el_reg <= '0;
            refresh_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            res_reg <= '0;
            af_reg <= '0;
            lf_reg <= '0;
            df_reg <= '0;
            for (int i = 0; i < ENTITIES; i++)
            begin
                acnt_reg[i] <= '0;
                lcp_reg[i] <= CP_INITIAL;
                lt_reg[i] <= '0;
                tv_reg[i] <= '0;
                dv_reg[i] <= '0;
            end
        end
        else
        begin
            st_reg <= st_next;
            idx_reg <= idx_next;
            if (out_ch.valid && out_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
            if (t_we)
            begin
                tv_reg[cmd.item.entity[EW-1:0]][cmd.item.rule_index[TW-1:0]] <=
                    cmd.item.rule_valid;
            end
            if (d_we)
            begin
                dv_reg[cmd.item.entity[EW-1:0]][cmd.item.rule_index[DW-1:0]] <=
                    cmd.item.rule_valid;
            end
            unique case (st_reg)
                S_IDLE:
                begin
                    tfound_reg <= 1'b0;
                    dfound_reg <= 1'b0;
                    ddone_reg <= 1'b0;
                    refresh_reg <= 1'b1;
                    if (cmd_take && cmd.item.mode == MODE_CYCLE && in_use == 5'd0)
                    begin
                        refresh_reg <= 1'b1;
                    end
                end
                S_SCAN:
                begin
                    if (t_hit)
                    begin
                        tfound_reg <= 1'b1;
                    end
                    if (d_hit && !dfound_reg && lcp_reg[ent] != CP_INITIAL)
                    begin
                        dfound_reg <= 1'b1;
                        dslot_reg <= prev[DW-1:0];
                    end
                end
                S_CYCLE:
                begin
                    if (idx_reg < SW'(in_use))
                    begin
                        af_reg[ce] <= !alive_ok;
                        acnt_reg[ce] <= '0;
                        if (!alive_ok || lf_reg[ce] || df_reg[ce])
                        begin
                            refresh_reg <= 1'b0;
                        end
                    end
                end
                S_DCHK:
                begin
                    // Limits of the chosen slot arrive on the RAM outputs next cycle.
                    ddone_reg <= dfound_reg;
                    el_reg <= c_reg.item.now_ms - lt_reg[ent];
                end
                S_OUT:
                begin
                    ovalid_reg <= 1'b1;
                    res_reg.accepted <= 1'b0;
                    res_reg.watchdog_refresh <= 1'b0;
                    res_reg.logical_violation <= 1'b0;
                    res_reg.deadline_violation <= 1'b0;
                    res_reg.entity_status <= status;
                    unique case (c_reg.item.mode)
                        MODE_CHECKPOINT:
                        begin
                            if (c_reg.ent_ok)
                            begin
                                res_reg.accepted <= 1'b1;
                                res_reg.logical_violation <= lviol;
                                res_reg.deadline_violation <= dviol;
                                acnt_reg[ent] <= acnt_reg[ent] + 8'd1;
                                if (lviol)
                                begin
                                    lf_reg[ent] <= 1'b1;
                                end
                                if (dviol)
                                begin
                                    df_reg[ent] <= 1'b1;
                                end
                                lcp_reg[ent] <= c_reg.item.checkpoint;
                                lt_reg[ent] <= c_reg.item.now_ms;
                                res_reg.entity_status <= (af_reg[ent] || lf_reg[ent]
                                    || df_reg[ent] || lviol || dviol)
                                    ? STATUS_FAILED : STATUS_OK;
                            end
                        end
                        MODE_CYCLE:
                        begin
                            res_reg.accepted <= 1'b1;
                            res_reg.watchdog_refresh <= refresh_reg;
                        end
                        MODE_RESUME, MODE_CLEAR:
                        begin
                            res_reg.accepted <= 1'b1;
                            for (int i = 0; i < ENTITIES; i++)
                            begin
                                lcp_reg[i] <= CP_INITIAL;
                                lt_reg[i] <= c_reg.item.now_ms;
                            end
                            if (c_reg.item.mode == MODE_CLEAR)
                            begin
                                af_reg <= '0;
                                lf_reg <= '0;
                                df_reg <= '0;
                                res_reg.entity_status <= (status == STATUS_DEACT)
                                    ? STATUS_DEACT : STATUS_OK;
                                for (int i = 0; i < ENTITIES; i++)
                                begin
                                    acnt_reg[i] <= '0;
                                end
                            end
                        end
                        MODE_WR_TRANS, MODE_WR_DEAD:
                        begin
                            res_reg.accepted <= c_reg.ent_ok;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_ch.valid = ovalid_reg;
    assign out_ch.accepted = res_reg.accepted;
    assign out_ch.entity_status = res_reg.entity_status;
    assign out_ch.watchdog_refresh = res_reg.watchdog_refresh;
    assign out_ch.logical_violation = res_reg.logical_violation;
    assign out_ch.deadline_violation = res_reg.deadline_violation;

    `ASSERT_IMPL(a_take_idle, clk, rst_n, cmd_take, st_reg == S_IDLE && !ovalid_reg)
    `ASSERT_NEXT(a_out_after, clk, rst_n, st_reg == S_OUT, ovalid_reg)
    `ASSERT_IMPL(a_refresh_cycle, clk, rst_n, ovalid_reg && res_reg.watchdog_refresh,
                 res_reg.accepted && !res_reg.logical_violation)
endmodule

// ----- src/watchdog_supervision_manager.sv -----
// Top level of the watchdog supervision manager: configuration registers and the two parts.
//
// The block supervises up to ENTITIES entities with alive, logical and deadline
// supervision and returns one result beat for every input beat. A front part takes
// input beats into a two-entry command queue, checking the entity and rule slot
// ranges on the way in; a back part executes one command at a time. A checkpoint
// report for an entity in range scans the entity's transition and deadline tables,
// one slot a cycle through registered-read RAMs, reads the matched deadline slot's
// limits in a check state and then goes to the output state. A supervision cycle
// walks the entities in use, one a cycle, visiting the walk state even when none is
// in use. Other modes, and checkpoints out of range, go straight to the output state.
// The result is held in an output register, so the front part keeps accepting beats
// while a result waits, until both queue entries are full. Configuration writes are
// always taken and must only be made while the block is idle.
module watchdog_supervision_manager #(
    parameter int ENTITIES = wsm_pkg::ENTITIES_DEF,
    parameter int TRANSITIONS_PER_ENTITY = wsm_pkg::TRANSITIONS_DEF,
    parameter int DEADLINES_PER_ENTITY = wsm_pkg::DEADLINES_DEF
) (
    input logic       clk,
    input logic       rst_n,
    wsm_in_if.sink    in_ch,
    wsm_out_if.source out_ch,
    wsm_cfg_if.sink   cfg
);
    import wsm_pkg::*;

    logic [2:0] entity_count_reg;
    logic [7:0] alive_min_reg [ALIVE_REGS];
    cmd_t       cmd;
    logic       cmd_valid;
    logic       cmd_take;

    // Configuration writes complete at once.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entity_count_reg <= '0;
            for (int i = 0; i < ALIVE_REGS; i++)
            begin
                alive_min_reg[i] <= 8'd1;
            end
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_ENTITY_COUNT)
            begin
                entity_count_reg <= cfg.data[2:0];
            end
            else if (cfg.index >= CFG_ALIVE_MIN0 && cfg.index <= CFG_ALIVE_MIN3)
            begin
                alive_min_reg[2'(cfg.index - CFG_ALIVE_MIN0)] <= cfg.data;
            end
        end
    end

    wsm_front #(
        .ENTITIES(ENTITIES),
        .TRANSITIONS(TRANSITIONS_PER_ENTITY),
        .DEADLINES(DEADLINES_PER_ENTITY)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .entity_count(entity_count_reg),
        .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take));

    wsm_back #(
        .ENTITIES(ENTITIES),
        .TRANSITIONS(TRANSITIONS_PER_ENTITY),
        .DEADLINES(DEADLINES_PER_ENTITY)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
        .entity_count(entity_count_reg), .alive_min(alive_min_reg), .out_ch(out_ch));
endmodule
